// ----- hw/rtl/mpfb_pkg.sv -----
package mpfb_pkg;

   localparam int FB_WIDTH  = 128;
   localparam int FB_HEIGHT = 64;
   localparam int FB_PAGES  = (FB_HEIGHT + 7) / 8;
   localparam int FB_BYTES  = FB_WIDTH * FB_PAGES;
   localparam int ADDR_W    = $clog2(FB_BYTES);
   localparam int COORD_W   = 14;
   localparam int REQ_W     = 72;
   localparam int RSP_W     = 16;

   localparam logic [2:0] BIT_FIRST = 3'd0;
   localparam logic [2:0] BIT_LAST  = 3'd7;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_PIXEL = 2'd1,
      OP_BLIT  = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_ISSUE,
      ST_COMMIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       load;
      logic       sweep;
      logic       issue;
      logic       commit;
      logic       rsp_load;
      logic [2:0] bit_idx;
   } cmd_type;

   typedef struct packed {
      op_type in_op;
      op_type op;
      logic   sweep_last;
   } status_type;

endpackage

// ----- hw/rtl/mpfb_ram.sv -----
module mpfb_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/mpfb_ctrl.sv -----
module mpfb_ctrl
   import mpfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [2:0] bit_ff, bit_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       rsp_free;

   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      bit_in   = bit_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            bit_in = BIT_FIRST;
            if (accept) begin
               state_in = (status.in_op == OP_CLEAR) ? ST_CLEAR : ST_ISSUE;
            end
         end
         ST_CLEAR: begin
            if (status.sweep_last) begin
               state_in = ST_DONE;
            end
         end
         ST_ISSUE: begin
            if (status.op == OP_BLIT && bit_ff != BIT_LAST) begin
               bit_in = bit_ff + 3'd1;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.bit_idx = bit_ff;
      req_tready  = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.sweep = 1'b1;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
         end
         ST_ISSUE: begin
            cmd.issue  = 1'b1;
            cmd.commit = (bit_ff != BIT_FIRST);
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
         end
         ST_DONE: begin
            cmd.rsp_load = rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         bit_ff       <= BIT_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.sweep |-> !cmd.issue && !cmd.commit && !req_tready)
      else $error("sweep overlaps item work");

   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before transaction");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |=> (state_ff == ST_DONE))
      else $error("commit not followed by done");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE && status.op != OP_BLIT) |-> (bit_ff == BIT_FIRST))
      else $error("bit counter moved outside blit");

endmodule

// ----- hw/rtl/mpfb_datapath.sv -----
module mpfb_datapath
   import mpfb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [REQ_W-1:0] req_tdata,
   input  cmd_type          cmd,
   output status_type       status,
   output logic [RSP_W-1:0] rsp_tdata
);

   op_type             op_ff;
   logic signed [11:0] px_ff;
   logic signed [11:0] py_ff;
   logic               color_ff;
   logic [7:0]         bw_ff;
   logic [7:0]         brow_ff;
   logic [4:0]         bcol_ff;
   logic [7:0]         bbyte_ff;
   logic [2:0]         page_ff;
   logic [6:0]         column_ff;

   logic [ADDR_W-1:0]  sweep_addr_ff;
   logic               pend_en_ff;
   logic [ADDR_W-1:0]  pend_addr_ff;
   logic [7:0]         pend_mask_ff;
   logic               pend_set_ff;
   logic [7:0]         rdata_res_ff;
   logic [3:0]         drawn_ff;
   logic [7:0]         rsp_read_data_ff;
   logic [3:0]         rsp_drawn_ff;

   logic [7:0]                col;
   logic [7:0]                col_add;
   logic [7:0]                row_add;
   logic signed [COORD_W-1:0] x;
   logic signed [COORD_W-1:0] y;
   logic                      on_screen;
   logic                      bit_set;
   logic                      col_ok;
   logic                      issue_en;
   logic [ADDR_W-1:0]         issue_addr;
   logic [7:0]                issue_mask;
   logic                      read_in_range;
   logic                      sweep_last;
   logic                      ram_we;
   logic [ADDR_W-1:0]         ram_waddr;
   logic [7:0]                ram_wdata;
   logic [7:0]                ram_rdata;

   localparam logic [ADDR_W-1:0] WIDTH_A = ADDR_W'(FB_WIDTH);
   localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(FB_BYTES - 1);

   assign col     = {bcol_ff, cmd.bit_idx};
   assign col_add = (op_ff == OP_BLIT) ? col : 8'd0;
   assign row_add = (op_ff == OP_BLIT) ? brow_ff : 8'd0;
   assign x = COORD_W'(px_ff) + $signed({6'd0, col_add});
   assign y = COORD_W'(py_ff) + $signed({6'd0, row_add});

   assign on_screen = !x[COORD_W-1] && (x[COORD_W-2:0] < (COORD_W-1)'(FB_WIDTH))
                   && !y[COORD_W-1] && (y[COORD_W-2:0] < (COORD_W-1)'(FB_HEIGHT));
   assign bit_set   = bbyte_ff[~cmd.bit_idx];
   assign col_ok    = (col < bw_ff);

   always_comb begin
      case (op_ff)
         OP_PIXEL: issue_en = on_screen;
         OP_BLIT:  issue_en = on_screen && bit_set && col_ok;
         default:  issue_en = 1'b0;
      endcase
   end

   always_comb begin
      if (op_ff == OP_READ) begin
         issue_addr = ADDR_W'(column_ff) + ADDR_W'(page_ff) * WIDTH_A;
      end else begin
         issue_addr = ADDR_W'(x[COORD_W-2:0]) + ADDR_W'(y[COORD_W-2:3]) * WIDTH_A;
      end
   end

   assign issue_mask    = 8'd1 << y[2:0];
   assign read_in_range = (32'(page_ff) < FB_PAGES) && (32'(column_ff) < FB_WIDTH);
   assign sweep_last    = (sweep_addr_ff == LAST_A);

   assign ram_we    = cmd.sweep || (cmd.commit && pend_en_ff);
   assign ram_waddr = cmd.sweep ? sweep_addr_ff : pend_addr_ff;
   assign ram_wdata = cmd.sweep   ? 8'd0 :
                      pend_set_ff ? (ram_rdata | pend_mask_ff) : (ram_rdata & ~pend_mask_ff);

   mpfb_ram #(
      .DATA_W(8),
      .DEPTH (FB_BYTES)
   ) u_frame_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(issue_addr),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_addr_ff <= '0;
         pend_en_ff    <= 1'b0;
      end else begin
         if (cmd.load || (cmd.sweep && sweep_last)) begin
            sweep_addr_ff <= '0;
         end else if (cmd.sweep) begin
            sweep_addr_ff <= sweep_addr_ff + 1'b1;
         end
         if (cmd.issue) begin
            pend_en_ff <= issue_en;
         end else if (cmd.commit) begin
            pend_en_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= op_type'(req_tdata[1:0]);
         px_ff     <= $signed(req_tdata[13:2]);
         py_ff     <= $signed(req_tdata[25:14]);
         color_ff  <= req_tdata[26];
         bw_ff     <= req_tdata[34:27];
         brow_ff   <= req_tdata[42:35];
         bcol_ff   <= req_tdata[47:43];
         bbyte_ff  <= req_tdata[55:48];
         page_ff   <= req_tdata[58:56];
         column_ff <= req_tdata[65:59];
      end
      if (cmd.issue) begin
         pend_addr_ff <= issue_addr;
         pend_mask_ff <= issue_mask;
         pend_set_ff  <= (op_ff == OP_BLIT) || color_ff;
      end
      if (cmd.load) begin
         drawn_ff     <= 4'd0;
         rdata_res_ff <= 8'd0;
      end else if (cmd.commit) begin
         if (pend_en_ff) begin
            drawn_ff <= drawn_ff + 4'd1;
         end
         if (op_ff == OP_READ) begin
            rdata_res_ff <= read_in_range ? ram_rdata : 8'd0;
         end
      end
      if (cmd.rsp_load) begin
         rsp_read_data_ff <= rdata_res_ff;
         rsp_drawn_ff     <= drawn_ff;
      end
   end

   assign status.in_op      = op_type'(req_tdata[1:0]);
   assign status.op         = op_ff;
   assign status.sweep_last = sweep_last;

   assign rsp_tdata = {4'd0, rsp_drawn_ff, rsp_read_data_ff};

endmodule

// ----- hw/rtl/mono_page_framebuffer.sv -----
// Page-organised 1-bit framebuffer of FB_WIDTH x FB_HEIGHT pixels (128 x 64), one byte per
// column per eight-row page, held in a single 1024 x 8 dual-port RAM. Every request returns
// exactly one response. After reset the block sweeps the RAM to zero, one byte a cycle,
// with req_tready low; a clear-all request runs the same sweep.
// A pixel write or a byte read passes through one RAM read, one read-modify-write slot and
// one result load on its way from transaction to response; a blit byte touches eight
// column bytes, read and written back one per cycle through the RAM's
// read and write ports. A finished response waits in an output register while the next
// request is taken.
module mono_page_framebuffer
   import mpfb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // op, pos_x, pos_y, color, bitmap_width, bitmap_row, byte_column, bitmap_byte,
   // read_page, read_column
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // read_data, pixels_drawn
   output logic [RSP_W-1:0] rsp_tdata
);

   cmd_type    cmd;
   status_type status;

   mpfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   mpfb_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_tdata(req_tdata),
      .cmd      (cmd),
      .status   (status),
      .rsp_tdata(rsp_tdata)
   );

endmodule

// ----- tb/frame_checker.sv -----
module frame_checker
   import mpfb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   // op, pos_x, pos_y, color, bitmap_width, bitmap_row, byte_column, bitmap_byte,
   // read_page, read_column
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   // read_data, pixels_drawn
   input  logic [RSP_W-1:0] rsp_tdata,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [5:0]  pad;
      logic [6:0]  read_column;
      logic [2:0]  read_page;
      logic [7:0]  bitmap_byte;
      logic [4:0]  byte_column;
      logic [7:0]  bitmap_row;
      logic [7:0]  bitmap_width;
      logic        color;
      logic [11:0] pos_y;
      logic [11:0] pos_x;
      op_type      op;
   } req_fields_type;

   logic [7:0]       frame_shadow [FB_BYTES];
   logic [RSP_W-1:0] reply_queue [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // off-screen pixels are dropped and not counted
   function automatic logic [3:0] plot_pixel(int x, int y, logic value);
      int idx;
      if (x < 0 || x >= FB_WIDTH || y < 0 || y >= FB_HEIGHT)
         return 4'd0;
      idx = x + (y / 8) * FB_WIDTH;
      frame_shadow[idx][y % 8] = value;
      return 4'd1;
   endfunction

   function automatic logic [RSP_W-1:0] draw_and_read(req_fields_type r);
      int         px;
      int         py;
      int         col;
      logic [3:0] drawn;
      logic [7:0] rd;
      px    = $signed(r.pos_x);
      py    = $signed(r.pos_y);
      drawn = '0;
      rd    = '0;
      case (r.op)
         OP_CLEAR: begin
            foreach (frame_shadow[i])
               frame_shadow[i] = '0;
         end
         OP_PIXEL: begin
            drawn = plot_pixel(px, py, r.color);
         end
         OP_BLIT: begin
            // msb is the leftmost source pixel; only set bits are ored in
            for (int b = 0; b < 8; b++) begin
               col = int'(r.byte_column) * 8 + b;
               if (col < int'(r.bitmap_width) && r.bitmap_byte[7 - b])
                  drawn += plot_pixel(px + col, py + int'(r.bitmap_row), 1'b1);
            end
         end
         default: begin
            if (int'(r.read_page) < FB_PAGES && int'(r.read_column) < FB_WIDTH)
               rd = frame_shadow[int'(r.read_column) + int'(r.read_page) * FB_WIDTH];
         end
      endcase
      return {4'b0000, drawn, rd};
   endfunction

   always @(posedge clock) begin : watch
      logic [RSP_W-1:0] want;
      if (reset) begin
         reply_queue.delete();
         foreach (frame_shadow[i])
            frame_shadow[i] = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (reply_queue.size() == 0) begin
               $error("response transaction with nothing outstanding: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = reply_queue.pop_front();
               if (rsp_tdata[7:0] !== want[7:0]) begin
                  $error("read_data: expected %0h, got %0h", want[7:0], rsp_tdata[7:0]);
                  fail_count++;
               end
               if (rsp_tdata[11:8] !== want[11:8]) begin
                  $error("pixels_drawn: expected %0d, got %0d", want[11:8], rsp_tdata[11:8]);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            reply_queue.push_back(draw_and_read(req_fields_type'(req_tdata)));
      end
      pending = reply_queue.size();
   end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
   import mpfb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LONG_HOLD   = 300;
   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic [5:0]  pad;
      logic [6:0]  read_column;
      logic [2:0]  read_page;
      logic [7:0]  bitmap_byte;
      logic [4:0]  byte_column;
      logic [7:0]  bitmap_row;
      logic [7:0]  bitmap_width;
      logic        color;
      logic [11:0] pos_y;
      logic [11:0] pos_x;
      op_type      op;
   } req_fields_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   int fail_count;
   int pending;
   int cycles = 0;
   int sent_count [4] = '{0, 0, 0, 0};
   bit idling = 1'b1;
   bit hold_request = 1'b0;

   always #4 clock = ~clock;

   mono_page_framebuffer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   frame_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: random back-pressure bursts, plus one long hold-off on request
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end else if (hold_left == 0 && idling && $urandom_range(0, 4) == 0) begin
            hold_left = $urandom_range(1, 11);
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic req_fields_type fields(op_type op, int x, int y, logic color, int bw,
                                             int brow, int bcol, int bbyte, int page,
                                             int col);
      req_fields_type r;
      r              = '0;
      r.op           = op;
      r.pos_x        = 12'(x);
      r.pos_y        = 12'(y);
      r.color        = color;
      r.bitmap_width = 8'(bw);
      r.bitmap_row   = 8'(brow);
      r.byte_column  = 5'(bcol);
      r.bitmap_byte  = 8'(bbyte);
      r.read_page    = 3'(page);
      r.read_column  = 7'(col);
      return r;
   endfunction

   function automatic req_fields_type random_request();
      logic [95:0]    noise;
      req_fields_type r;
      int             pick;
      noise = {$urandom, $urandom, $urandom};
      r     = req_fields_type'(noise[REQ_W-1:0]);
      r.pad = '0;
      pick  = $urandom_range(0, 99);
      if (pick < 2)
         r.op = OP_CLEAR;
      else if (pick < 36)
         r.op = OP_PIXEL;
      else if (pick < 70)
         r.op = OP_BLIT;
      else
         r.op = OP_READ;
      // most items land on or near the screen; the rest keep fully random fields
      if ($urandom_range(0, 9) != 0) begin
         case (r.op)
            OP_PIXEL: begin
               r.pos_x = 12'($urandom_range(0, FB_WIDTH + 7) - 4);
               r.pos_y = 12'($urandom_range(0, FB_HEIGHT + 7) - 4);
            end
            OP_BLIT: begin
               r.pos_x        = 12'($urandom_range(0, FB_WIDTH + 23) - 16);
               r.pos_y        = 12'($urandom_range(0, FB_HEIGHT + 7) - 8);
               r.bitmap_row   = 8'($urandom_range(0, 15));
               r.byte_column  = 5'($urandom_range(0, 3));
               r.bitmap_width = 8'($urandom_range(0, 40));
            end
            default: begin
            end
         endcase
      end
      return r;
   endfunction

   task automatic send_item(req_fields_type r);
      @(negedge clock);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= r;
      do
         @(posedge clock);
      while (!req_tready);
      sent_count[r.op]++;
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset contents, corners, off-screen pixels, blit masking and clipping, clear
      send_item(fields(OP_READ,      0,    0, 1'b0,   0,   0,  0, 8'h00, 0,   0));
      send_item(fields(OP_READ,      0,    0, 1'b0,   0,   0,  0, 8'h00, 7, 127));
      send_item(fields(OP_PIXEL,     0,    0, 1'b1,   0,   0,  0, 8'h00, 0,   0));
      send_item(fields(OP_PIXEL,   127,   63, 1'b1, 255, 255, 31, 8'hff, 7, 127));
      send_item(fields(OP_PIXEL,    -1,    0, 1'b1,   0,   0,  0, 8'h00, 0,   0));
      send_item(fields(OP_PIXEL,   128,    0, 1'b1,   0,   0,  0, 8'h00, 0,   0));
      send_item(fields(OP_PIXEL,     0,   64, 1'b1,   0,   0,  0, 8'h00, 0,   0));
      send_item(fields(OP_PIXEL,     0,   -1, 1'b1,   0,   0,  0, 8'h00, 0,   0));
      send_item(fields(OP_PIXEL, -2048, 2047, 1'b1,   0,   0,  0, 8'h00, 0,   0));
      send_item(fields(OP_PIXEL,  2047,-2048, 1'b1,   0,   0,  0, 8'h00, 0,   0));
      send_item(fields(OP_READ,      0,    0, 1'b0,   0,   0,  0, 8'h00, 0,   0));
      send_item(fields(OP_READ,      0,    0, 1'b0,   0,   0,  0, 8'h00, 7, 127));
      send_item(fields(OP_PIXEL,     0,    0, 1'b0,   0,   0,  0, 8'h00, 0,   0));
      send_item(fields(OP_BLIT,      0,    8, 1'b0,   8,   0,  0, 8'hff, 0,   0));
      send_item(fields(OP_BLIT,      0,    8, 1'b0,   3,   1,  0, 8'hff, 0,   0));
      send_item(fields(OP_BLIT,      0,    8, 1'b0,   0,   2,  0, 8'hff, 0,   0));
      send_item(fields(OP_BLIT,    124,    0, 1'b0, 255,   0,  0, 8'hff, 0,   0));
      send_item(fields(OP_BLIT,   -240,   16, 1'b0, 255,   0, 31, 8'ha5, 0,   0));
      send_item(fields(OP_BLIT,     40,   40, 1'b0, 255,   0,  0, 8'h00, 0,   0));
      send_item(fields(OP_BLIT,      0,   60, 1'b0, 255, 255,  0, 8'hff, 0,   0));
      send_item(fields(OP_READ,      0,    0, 1'b0,   0,   0,  0, 8'h00, 1,   0));
      send_item(fields(OP_READ,      0,    0, 1'b0,   0,   0,  0, 8'h00, 2,   8));
      send_item(fields(OP_CLEAR,     0,    0, 1'b0,   0,   0,  0, 8'h00, 0,   0));
      send_item(fields(OP_READ,      0,    0, 1'b0,   0,   0,  0, 8'h00, 1,   0));

      // long receiver hold-off while requests keep coming, then a full drain
      hold_request = 1'b1;
      repeat (24) send_item(random_request());
      stop_sending();
      wait (pending == 0);

      for (int blk = 0; blk < 8; blk++) begin
         idling = (blk != 3 && blk != 7);
         repeat (100) send_item(random_request());
      end
      stop_sending();

      wait (pending == 0);
      repeat (30) @(posedge clock);
      $display("sent %0d clears, %0d pixel writes, %0d blits and %0d reads",
               sent_count[OP_CLEAR], sent_count[OP_PIXEL], sent_count[OP_BLIT],
               sent_count[OP_READ]);
      $display("with off-screen and clipped drawing, one long output stall and one drain");
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
